// ===== hw/rtl/sci_pkg.sv =====
`timescale 1ns / 1ps

package sci_pkg;

  localparam int SampleW  = 24;
  localparam int GainW    = 16;
  localparam int GainFrac = 12;
  localparam int Taps     = 16;
  localparam int PosW     = 4;
  localparam int StepW    = 5;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;
  localparam int TabW     = 24;

  localparam logic [StepW-1:0] LastStep = StepW'(2 * Taps - 2);

  localparam logic [CfgIdxW-1:0] CfgGain = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSet  = 1'b1;

  localparam logic [GainW-1:0] GainReset = 16'd4096;

  // Q2.22, [set][k]: set 0 unmatched, set 1 matched
  localparam logic signed [TabW-1:0] FfTab [2][Taps] = '{
    '{-24'sd78, -24'sd8113, -24'sd28765, -24'sd33853, 24'sd26183, 24'sd125968,
      24'sd176580, 24'sd87690, -24'sd123046, -24'sd314007, -24'sd370730,
      -24'sd301633, -24'sd163261, -24'sd22794, 24'sd34367, 24'sd8667},
    '{24'sd4578947, 24'sd380842, 24'sd263228, 24'sd44490, -24'sd167911,
      -24'sd213856, -24'sd8893, 24'sd344640, 24'sd610608, 24'sd591732,
      24'sd287880, -24'sd93195, -24'sd286506, -24'sd172902, 24'sd134401,
      24'sd378488}
  };

  localparam logic signed [TabW-1:0] FbTab [2][Taps] = '{
    '{24'sd0, 24'sd2047995, 24'sd1422618, 24'sd17202, -24'sd1232110,
      -24'sd1314959, -24'sd395007, 24'sd511089, 24'sd673338, 24'sd44158,
      -24'sd816576, -24'sd1074112, -24'sd301819, 24'sd945090, 24'sd1085954,
      -24'sd1788428},
    '{24'sd0, 24'sd1073508, 24'sd850146, 24'sd418171, -24'sd71232,
      -24'sd420507, -24'sd519127, -24'sd412596, -24'sd242951, -24'sd115015,
      -24'sd31631, 24'sd59212, 24'sd144230, 24'sd84559, -24'sd306602,
      -24'sd1079315}
  };

  typedef struct packed {
    logic signed [SampleW-1:0] left_sample;
    logic signed [SampleW-1:0] right_sample;
  } sci_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left_filtered;
    logic signed [SampleW-1:0] right_filtered;
  } sci_out_t;

  typedef struct packed {
    logic             x_wr;
    logic             mac;
    logic [StepW-1:0] step;
    logic             acc_round;
    logic             y_wr;
    logic             gain_mul;
    logic [PosW-1:0]  pos;
    logic             set;
  } sci_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_HIST,
    ST_GAIN,
    ST_OUT
  } sci_state_e;

endpackage

// ===== hw/rtl/stereo_cabinet_iir_filter.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    sci_in_t   (left_sample, right_sample)
// out      output     out_valid/out_ready  sci_out_t  (left_filtered, right_filtered)
// cfg      input      cfg_we               cfg_idx, cfg_data
//
// After acceptance, a frame runs 31 MAC steps of the per-lane multiplier (b0, then
// b[k] and a[k] for k = 1..15), then drain, round, history write, gain multiply and
// output load; only then is input ready again.
// Reset clears the histories, ring position, gain (unity) and coefficient set.
// A result waits in the output register; the next frame is taken meanwhile, and only
// the final load stalls while the previous result is still held.

module stereo_cabinet_iir_filter
  import sci_pkg::*;
#(
  parameter int COEF_WIDTH = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sci_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sci_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  sci_state_e       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [GainW-1:0] gain_q;
  logic             set_q;
  logic             out_valid_q;
  sci_out_t         out_q;
  logic             out_load;
  sci_ctrl_t        ctrl;
  logic signed [SampleW-1:0] left_y;
  logic signed [SampleW-1:0] right_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
      set_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGain: gain_q <= cfg_data_i[GainW-1:0];
        CfgSet:  set_q  <= cfg_data_i[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pos_q   <= pos_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    pos_d          = pos_q;
    in_ready_o     = 1'b0;
    out_load       = 1'b0;
    ctrl           = '0;
    ctrl.step      = step_q;
    ctrl.pos       = pos_q;
    ctrl.set       = set_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl.x_wr = 1'b1;
          step_d    = '0;
          state_d   = ST_MAC;
        end
      end
      ST_MAC: begin
        ctrl.mac = 1'b1;
        if (step_q == LastStep) begin
          state_d = ST_DRAIN;
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      ST_DRAIN: state_d = ST_ROUND;
      ST_ROUND: begin
        ctrl.acc_round = 1'b1;
        state_d        = ST_HIST;
      end
      ST_HIST: begin
        ctrl.y_wr = 1'b1;
        state_d   = ST_GAIN;
      end
      ST_GAIN: begin
        ctrl.gain_mul = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          pos_d    = pos_q + PosW'(1);
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  sci_lane #(
    .CoefW(COEF_WIDTH)
  ) u_lane_left (
    .clk_i,
    .rst_ni,
    .ctrl_i     (ctrl),
    .sample_i   (in_data_i.left_sample),
    .gain_i     (gain_q),
    .filtered_o (left_y)
  );

  sci_lane #(
    .CoefW(COEF_WIDTH)
  ) u_lane_right (
    .clk_i,
    .rst_ni,
    .ctrl_i     (ctrl),
    .sample_i   (in_data_i.right_sample),
    .gain_i     (gain_q),
    .filtered_o (right_y)
  );

  // merge both lanes into the output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.left_filtered  <= left_y;
      out_q.right_filtered <= right_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/sci_lane.sv =====
`timescale 1ns / 1ps

module sci_lane
  import sci_pkg::*;
#(
  parameter int CoefW = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sci_ctrl_t                 ctrl_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic [GainW-1:0]          gain_i,
  output logic signed [SampleW-1:0] filtered_o
);

  localparam int AccW     = SampleW + CoefW;
  localparam int CoefFrac = CoefW - 2;
  localparam int ShUp     = (CoefW >= TabW) ? CoefW - TabW : 0;
  localparam int ShDn     = (CoefW < TabW) ? TabW - CoefW : 0;
  localparam int CoefHalf = (ShDn > 0) ? (1 << (ShDn - 1)) : 0;
  localparam int WideW    = 34;
  localparam int GpW      = SampleW + GainW + 1;
  localparam int GsW      = GpW - GainFrac;
  localparam int YsW      = AccW - CoefFrac;

  localparam logic signed [AccW-1:0] RoundHalf = AccW'(1) <<< (CoefFrac - 1);
  localparam logic signed [GpW-1:0]  GainHalf  = GpW'(1) <<< (GainFrac - 1);
  localparam logic signed [SampleW-1:0] SMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SMin = {1'b1, {(SampleW-1){1'b0}}};

  function automatic logic signed [CoefW-1:0] to_coef(logic signed [TabW-1:0] q);
    logic signed [WideW-1:0] w;
    if (CoefW >= TabW) begin
      w = WideW'(q) <<< ShUp;
    end else begin
      w = (WideW'(q) + WideW'(CoefHalf)) >>> ShDn;
    end
    return w[CoefW-1:0];
  endfunction

  function automatic logic signed [AccW-1:0] sat_add(logic signed [AccW-1:0] a,
                                                     logic signed [AccW-1:0] b);
    logic [AccW:0] s;
    s = {a[AccW-1], a} + {b[AccW-1], b};
    if (s[AccW] != s[AccW-1]) begin
      return s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end
    return s[AccW-1:0];
  endfunction

  logic signed [SampleW-1:0] xh_q [Taps];
  logic signed [SampleW-1:0] yh_q [Taps];
  logic signed [AccW-1:0]    prod_q;
  logic signed [AccW-1:0]    acc_q;
  logic                      mac_d1_q;
  logic                      first_d1_q;
  logic signed [SampleW-1:0] y_q;
  logic signed [GpW-1:0]     gprod_q;

  logic [StepW-1:0]          step_p1;
  logic [PosW-1:0]           tap_k;
  logic [PosW-1:0]           tap_idx;
  logic                      use_y;
  logic signed [TabW-1:0]    coef_q22;
  logic signed [CoefW-1:0]   coef_w;
  logic signed [SampleW-1:0] opnd;
  logic [YsW-1:0]            y_sh;
  logic signed [SampleW-1:0] y_sat;
  logic [GpW-1:0]            gsum;
  logic [GsW-1:0]            g_sh;

  assign step_p1  = ctrl_i.step + StepW'(1);
  assign tap_k    = step_p1[PosW:1];
  assign tap_idx  = ctrl_i.pos - tap_k;
  assign use_y    = (ctrl_i.step != '0) && !ctrl_i.step[0];
  assign coef_q22 = use_y ? FbTab[ctrl_i.set][tap_k] : FfTab[ctrl_i.set][tap_k];
  assign coef_w   = to_coef(coef_q22);
  assign opnd     = use_y ? yh_q[tap_idx] : xh_q[tap_idx];

  always_comb begin
    y_sh = acc_q[AccW-1:CoefFrac];
    if ((&y_sh[YsW-1:SampleW-1]) || !(|y_sh[YsW-1:SampleW-1])) begin
      y_sat = y_sh[SampleW-1:0];
    end else begin
      y_sat = y_sh[YsW-1] ? SMin : SMax;
    end
  end

  always_comb begin
    gsum = gprod_q + GainHalf;
    g_sh = gsum[GpW-1:GainFrac];
    if ((&g_sh[GsW-1:SampleW-1]) || !(|g_sh[GsW-1:SampleW-1])) begin
      filtered_o = g_sh[SampleW-1:0];
    end else begin
      filtered_o = g_sh[GsW-1] ? SMin : SMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Taps; i++) begin
        xh_q[i] <= '0;
        yh_q[i] <= '0;
      end
    end else begin
      if (ctrl_i.x_wr) begin
        xh_q[ctrl_i.pos] <= sample_i;
      end
      if (ctrl_i.y_wr) begin
        yh_q[ctrl_i.pos] <= y_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_d1_q   <= 1'b0;
      first_d1_q <= 1'b0;
    end else begin
      mac_d1_q   <= ctrl_i.mac;
      first_d1_q <= ctrl_i.mac && (ctrl_i.step == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mac) begin
      prod_q <= AccW'(opnd) * AccW'(coef_w);
    end
    if (mac_d1_q) begin
      acc_q <= first_d1_q ? prod_q : sat_add(acc_q, prod_q);
    end else if (ctrl_i.acc_round) begin
      acc_q <= sat_add(acc_q, RoundHalf);
    end
    if (ctrl_i.y_wr) begin
      y_q <= y_sat;
    end
    if (ctrl_i.gain_mul) begin
      gprod_q <= GpW'(y_q) * GpW'($signed({1'b0, gain_i}));
    end
  end

endmodule

// ===== hw/rtl/sci_checker.sv =====
`timescale 1ns / 1ps

module sci_checker
  import sci_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input sci_out_t            out_data_o
);

  // one frame in flight: ready drops after each accepted input beat
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("in_ready stayed high after an input beat");

  // a result never appears right after an input beat
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("output valid rose one cycle after an input beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // an edge seen in reset leaves the block idle at the next edge
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && in_ready_o)
    else $error("block not idle after reset");

endmodule

bind stereo_cabinet_iir_filter sci_checker u_sci_checker (.*);
